### hdl/cln_pkg.sv
// ----------------------------------------------------------------------------
// cln_pkg
// Shared types and constants of the character LCD number writer.
// ----------------------------------------------------------------------------
`default_nettype none

package cln_pkg;

    // field widths of the request and bus write items
    localparam int CMD_W    = 3;
    localparam int LINE_W   = 2;
    localparam int COL_W    = 6;
    localparam int VALUE_W  = 16;
    localparam int LEN_W    = 5;
    localparam int BYTE_W   = 8;

    // digit handling
    localparam int MAX_DIGITS = 16;
    localparam int POS_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int DIG_W      = 4 * MAX_DIGITS;
    localparam int DEC_DIGITS = 5;
    localparam int DEC_W      = 4 * DEC_DIGITS;
    localparam int CONV_CNT_W = $clog2(DEC_DIGITS + 1);

    // divide by ten through a reciprocal, exact for 16-bit values
    localparam logic [16:0] DEC_RECIP = 17'd52429;
    localparam int          DEC_SHIFT = 19;

    // decoupling queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // request modes
    localparam logic [CMD_W-1:0] CMD_CHAR = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UDEC = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SDEC = 3'd2;
    localparam logic [CMD_W-1:0] CMD_HEX  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_BIN  = 3'd4;

    localparam logic [LINE_W-1:0] LINE_FIRST = 2'd1;

    // bus bytes
    localparam logic [BYTE_W-1:0] ADDR_CMD     = 8'h80;
    localparam logic [BYTE_W-1:0] LINE2_OFFSET = 8'h40;
    localparam logic [BYTE_W-1:0] ASCII_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_A      = 8'h41;
    localparam logic [BYTE_W-1:0] ASCII_PLUS   = 8'h2B;
    localparam logic [BYTE_W-1:0] ASCII_MINUS  = 8'h2D;

    // classified request handed from front to back
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [BYTE_W-1:0]  addr_byte;
        logic [VALUE_W-1:0] mag;
        logic               neg;
        logic [LEN_W-1:0]   len;
    } job_t;

    // ascii character of one digit
    function automatic logic [BYTE_W-1:0] digit_char(input logic [3:0] d);
        logic [BYTE_W-1:0] c;
        if (d < 4'd10)
            c = ASCII_ZERO + {4'b0000, d};
        else
            c = ASCII_A + {4'b0000, d} - 8'd10;
        return c;
    endfunction

endpackage

`default_nettype wire

### hdl/cln_req_if.sv
// ----------------------------------------------------------------------------
// cln_req_if
// Request channel: cursor position, mode, value and digit count.
// ----------------------------------------------------------------------------
`default_nettype none

interface cln_req_if
    import cln_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [LINE_W-1:0]  line;
    logic [COL_W-1:0]   column;
    logic [VALUE_W-1:0] value;
    logic [LEN_W-1:0]   length;

    modport source (output valid, cmd, line, column, value, length, input ready);
    modport sink   (input valid, cmd, line, column, value, length, output ready);
endinterface

`default_nettype wire

### hdl/cln_wr_if.sv
// ----------------------------------------------------------------------------
// cln_wr_if
// LCD bus write channel: register select, data byte and end of run.
// ----------------------------------------------------------------------------
`default_nettype none

interface cln_wr_if
    import cln_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              is_data;
    logic [BYTE_W-1:0] bus_byte;
    logic              last;

    modport source (output valid, is_data, bus_byte, last, input ready);
    modport sink   (input valid, is_data, bus_byte, last, output ready);
endinterface

`default_nettype wire

### hdl/cln_front.sv
// ----------------------------------------------------------------------------
// cln_front
// Accepts requests, forms the address command, magnitude and sign, and
// saturates the digit count.
// ----------------------------------------------------------------------------
`default_nettype none

module cln_front
    import cln_pkg::*;
(
    cln_req_if.sink    req,
    input  wire logic  queue_full,
    output logic       push_valid,
    output job_t       push_job
);

    logic [BYTE_W-1:0] addr;

    assign req.ready  = !queue_full;
    assign push_valid = req.valid;

    // set-address command byte
    always_comb
    begin
        addr = BYTE_W'({2'b00, req.column} + 8'hFF);
        if (req.line != LINE_FIRST)
            addr = addr + LINE2_OFFSET;
    end

    // classify the request
    always_comb
    begin
        push_job.cmd       = req.cmd;
        push_job.addr_byte = ADDR_CMD | addr;
        push_job.neg       = 1'b0;
        push_job.mag       = req.value;
        if (req.cmd == CMD_SDEC && req.value[VALUE_W-1])
        begin
            push_job.neg = 1'b1;
            push_job.mag = VALUE_W'(~req.value + 16'd1);
        end
        if (req.length > LEN_W'(MAX_DIGITS))
            push_job.len = LEN_W'(MAX_DIGITS);
        else
            push_job.len = req.length;
    end

endmodule

`default_nettype wire

### hdl/cln_queue.sv
// ----------------------------------------------------------------------------
// cln_queue
// Short queue of classified requests between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module cln_queue
    import cln_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    input  wire job_t push_job,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output job_t      head_job
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

### hdl/cln_back.sv
// ----------------------------------------------------------------------------
// cln_back
// Write sequencer: converts the magnitude to digits and issues the address
// command, sign or character, and digits through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cln_back
    import cln_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic head_valid,
    input  wire job_t head_job,
    output logic      pop,
    cln_wr_if.source  wr
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_ADDR = 3'd2;
    localparam logic [2:0] S_CHAR = 3'd3;
    localparam logic [2:0] S_SIGN = 3'd4;
    localparam logic [2:0] S_DIG  = 3'd5;

    logic [2:0]            state_reg, state_next;
    job_t                  job_reg, job_next;
    logic [VALUE_W-1:0]    x_reg, x_next;
    logic [DEC_W-1:0]      dec_reg, dec_next;
    logic [DIG_W-1:0]      dig_reg, dig_next;
    logic [CONV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [POS_W-1:0]      pos_reg, pos_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  is_data_reg, is_data_next;
    logic [BYTE_W-1:0]     byte_reg, byte_next;
    logic                  last_reg, last_next;

    logic                  slot_free;
    logic                  is_dec, is_num;
    logic [31:0]           prod;
    logic [VALUE_W-1:0]    quot;
    logic [3:0]            rem;
    logic [3:0]            nib;
    logic [DIG_W-1:0]      bin_word;

    assign wr.valid    = out_valid_reg;
    assign wr.is_data  = is_data_reg;
    assign wr.bus_byte = byte_reg;
    assign wr.last     = last_reg;

    assign slot_free = !out_valid_reg || wr.ready;
    assign is_dec    = (job_reg.cmd == CMD_UDEC) || (job_reg.cmd == CMD_SDEC);
    assign is_num    = is_dec || (job_reg.cmd == CMD_HEX) || (job_reg.cmd == CMD_BIN);
    assign pop       = (state_reg == S_IDLE) && head_valid;

    // one decimal digit per step: divide by ten via reciprocal
    assign prod = 32'(x_reg) * 32'(DEC_RECIP);
    assign quot = VALUE_W'(prod >> DEC_SHIFT);
    assign rem  = 4'(x_reg - VALUE_W'({quot, 3'b000}) - VALUE_W'({quot, 1'b0}));

    // binary digits, one bit to a nibble
    always_comb
    begin
        bin_word = '0;
        for (int k = 0; k < MAX_DIGITS; k++)
            bin_word[4*k] = head_job.mag[k];
    end

    // digit at the current position
    always_comb
    begin
        if (is_dec)
            nib = 4'(dec_reg >> {pos_reg, 2'b00});
        else
            nib = 4'(dig_reg >> {pos_reg, 2'b00});
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        x_next         = x_reg;
        dec_next       = dec_reg;
        dig_next       = dig_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && !wr.ready;
        is_data_next   = is_data_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    job_next = head_job;
                    x_next   = head_job.mag;
                    dec_next = '0;
                    cnt_next = '0;
                    if (head_job.cmd == CMD_HEX)
                        dig_next = DIG_W'(head_job.mag);
                    else
                        dig_next = bin_word;
                    if (head_job.cmd == CMD_UDEC || head_job.cmd == CMD_SDEC)
                        state_next = S_CONV;
                    else
                        state_next = S_ADDR;
                end
            end
            S_CONV:
            begin
                x_next   = quot;
                dec_next = {rem, dec_reg[DEC_W-1:4]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CONV_CNT_W'(DEC_DIGITS - 1))
                    state_next = S_ADDR;
            end
            S_ADDR:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    is_data_next   = 1'b0;
                    byte_next      = job_reg.addr_byte;
                    last_next      = 1'b1;
                    pos_next       = POS_W'(job_reg.len - 1'b1);
                    state_next     = S_IDLE;
                    if (job_reg.cmd == CMD_CHAR)
                    begin
                        last_next  = 1'b0;
                        state_next = S_CHAR;
                    end
                    else if (job_reg.cmd == CMD_SDEC)
                    begin
                        last_next  = 1'b0;
                        state_next = S_SIGN;
                    end
                    else if (is_num && job_reg.len != '0)
                    begin
                        last_next  = 1'b0;
                        state_next = S_DIG;
                    end
                end
            end
            S_CHAR:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    is_data_next   = 1'b1;
                    byte_next      = job_reg.mag[BYTE_W-1:0];
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_SIGN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    is_data_next   = 1'b1;
                    byte_next      = job_reg.neg ? ASCII_MINUS : ASCII_PLUS;
                    last_next      = (job_reg.len == '0);
                    state_next     = (job_reg.len == '0) ? S_IDLE : S_DIG;
                end
            end
            S_DIG:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    is_data_next   = 1'b1;
                    byte_next      = digit_char(nib);
                    last_next      = (pos_reg == '0);
                    pos_next       = pos_reg - 1'b1;
                    if (pos_reg == '0)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and output payload
    always_ff @(posedge clk)
    begin
        job_reg     <= job_next;
        x_reg       <= x_next;
        dec_reg     <= dec_next;
        dig_reg     <= dig_next;
        cnt_reg     <= cnt_next;
        pos_reg     <= pos_next;
        is_data_reg <= is_data_next;
        byte_reg    <= byte_next;
        last_reg    <= last_next;
    end

endmodule

`default_nettype wire

### hdl/char_lcd_number_writer_core.sv
// Flow: a transferred request is queued and taken by the idle sequencer; the decimal
//   modes then run five divide-by-ten steps before the address command is issued.
// Throughput: one bus write per cycle within a run while the sink is ready; a request
//   holds the sequencer from idle until the last write of its run is issued.
// A two-entry queue lets requests be taken while a run is still being written.
// Reset: rst_n clears the queue, the sequencer and the output valid at once.
// ----------------------------------------------------------------------------
// char_lcd_number_writer_core
// Turns cursor-and-number requests into character LCD bus writes.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_number_writer_core
    import cln_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    cln_req_if.sink   req,
    cln_wr_if.source  wr
);

    logic push_valid;
    job_t push_job;
    logic queue_full;
    logic pop;
    logic head_valid;
    job_t head_job;

    // request classification
    cln_front u_front (
        .req        (req),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_job   (push_job)
    );

    // decoupling queue
    cln_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_job   (push_job),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // write sequencer
    cln_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .wr         (wr)
    );

endmodule

`default_nettype wire

### hdl/cln_checker.sv
// ----------------------------------------------------------------------------
// cln_checker
// Port-level checks on the bus write channel of the number writer.
// ----------------------------------------------------------------------------
`default_nettype none

module cln_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       wr_valid,
    input wire logic       wr_ready,
    input wire logic       wr_is_data,
    input wire logic [7:0] wr_bus_byte,
    input wire logic       wr_last
);

    logic xfer;
    logic run_start_reg;

    assign xfer = wr_valid && wr_ready;

    // set after reset and after each final write of a run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_start_reg <= 1'b1;
        else if (xfer)
            run_start_reg <= wr_last;
    end

    // no write offered during reset
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !wr_valid)
        else $error("write valid during reset");

    // stalled write stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && !wr_ready |=> wr_valid)
        else $error("write withdrawn while stalled");

    // every run opens with an address command
    a_run_opens: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && run_start_reg |-> !wr_is_data)
        else $error("run does not open with an address command");

    // only the opening write of a run is a command
    a_body_data: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && !run_start_reg |-> wr_is_data)
        else $error("command write inside a run");

    // command bytes carry the set-address bit
    a_cmd_byte: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && !wr_is_data |-> wr_bus_byte[7])
        else $error("command byte without set-address bit");

endmodule

bind char_lcd_number_writer_core cln_checker u_cln_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_valid    (wr.valid),
    .wr_ready    (wr.ready),
    .wr_is_data  (wr.is_data),
    .wr_bus_byte (wr.bus_byte),
    .wr_last     (wr.last)
);

`default_nettype wire
